/* rtl/ffra_pkg.sv */
// ============================================================================
// ffra_pkg
// Shared types, constants and status codes of the first-fit region allocator.
// ============================================================================
package ffra_pkg;

    localparam int MAX_FREE_REGIONS = 64;
    localparam int ADDR_BITS        = 24;
    localparam int IDX_BITS         = $clog2(MAX_FREE_REGIONS);
    localparam int CNT_BITS         = IDX_BITS + 1;
    localparam int SIZE_BITS        = 25;
    localparam int ALIGN_BITS       = 17;
    localparam int RAM_WIDTH        = 2 * ADDR_BITS;

    localparam logic [SIZE_BITS-1:0] USED_MAX = '1;
    localparam logic [SIZE_BITS-1:0] POOL_RESET = SIZE_BITS'(25'd16777216);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_NOFIT = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_EVAL,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EDIT,
        S_EDIT2,
        S_DONE,
        S_OUT
    } state_t;

    // Datapath commands from the controller.
    typedef struct packed {
        logic                load_req;
        logic                clr_scan;
        logic                inc_scan;
        logic                rd_scan;
        logic                eval;
        logic                shift_rd;
        logic                shift_wr;
        logic                edit;
        logic                edit2;
        logic                finish;
        logic                out_valid_set;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    req_bad;
        logic    scan_end;
        logic    hit;
        logic    need_open;
        logic    need_close;
        logic    full;
        logic    shift_end;
        logic    is_free;
        logic    two_edits;
    } stat_t;

endpackage

/* rtl/ffra_ram.sv */
// ============================================================================
// ffra_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ffra_ctrl.sv */
// ============================================================================
// ffra_ctrl
// Sequencer of the allocator: table walk, entry shifting and result handoff.
// ============================================================================
module ffra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_fire,
    input  logic            cfg_we,
    input  ffra_pkg::stat_t st,
    output ffra_pkg::cmd_t  cmd,
    output logic            idle
);

    ffra_pkg::state_t state_reg;
    ffra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffra_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        idle       = 1'b0;
        case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load_req = 1'b1;
                    cmd.clr_scan = 1'b1;
                    state_next   = ffra_pkg::S_CHECK;
                end
            end
            ffra_pkg::S_CHECK:
            begin
                if (st.req_bad)
                begin
                    state_next = ffra_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ffra_pkg::S_RD;
                end
            end
            ffra_pkg::S_RD:
            begin
                state_next = ffra_pkg::S_EVAL;
            end
            ffra_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (st.hit || st.scan_end)
                begin
                    if (st.full || !st.hit)
                    begin
                        state_next = ffra_pkg::S_DONE;
                    end
                    else if (st.need_open || st.need_close)
                    begin
                        state_next = ffra_pkg::S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = ffra_pkg::S_EDIT;
                    end
                end
                else
                begin
                    cmd.inc_scan = 1'b1;
                    cmd.rd_scan  = 1'b1;
                    state_next   = ffra_pkg::S_RD;
                end
            end
            ffra_pkg::S_SHIFT_RD:
            begin
                if (st.shift_end)
                begin
                    // An allocate that consumes a whole region only closes
                    // the gap; every other shift is followed by an edit.
                    if (st.is_free || st.two_edits)
                    begin
                        state_next = ffra_pkg::S_EDIT;
                    end
                    else
                    begin
                        state_next = ffra_pkg::S_DONE;
                    end
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ffra_pkg::S_SHIFT_WR;
                end
            end
            ffra_pkg::S_SHIFT_WR:
            begin
                state_next = ffra_pkg::S_SHIFT_RD;
            end
            ffra_pkg::S_EDIT:
            begin
                cmd.edit     = 1'b1;
                state_next   = st.two_edits ? ffra_pkg::S_EDIT2 : ffra_pkg::S_DONE;
            end
            ffra_pkg::S_EDIT2:
            begin
                cmd.edit2  = 1'b1;
                state_next = ffra_pkg::S_DONE;
            end
            ffra_pkg::S_DONE:
            begin
                cmd.finish        = 1'b1;
                cmd.out_valid_set = 1'b1;
                state_next        = ffra_pkg::S_OUT;
            end
            ffra_pkg::S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
        if (state_reg == ffra_pkg::S_SHIFT_WR)
        begin
            cmd.shift_wr = 1'b1;
        end
        if (cfg_we)
        begin
            state_next = ffra_pkg::S_IDLE;
        end
    end

    // A configuration write must only arrive while idle; the block itself does not enforce this.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> (state_reg == ffra_pkg::S_IDLE))
        else $error("configuration write while busy");
    a_edit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffra_pkg::S_EDIT2) |=> (state_reg == ffra_pkg::S_DONE))
        else $error("second edit not followed by completion");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffra_pkg::S_OUT && !out_fire) |=> (state_reg == ffra_pkg::S_OUT))
        else $error("result dropped before transfer");

endmodule

/* rtl/ffra_dp.sv */
// ============================================================================
// ffra_dp
// Datapath: free-region table in RAM, walk index, fit check and bookkeeping.
// ============================================================================
module ffra_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ffra_pkg::cmd_t                   cmd,
    output ffra_pkg::stat_t                  st,
    input  logic                             cfg_we,
    input  logic [ffra_pkg::SIZE_BITS-1:0]   cfg_wdata,
    input  logic                             op,
    input  logic [ffra_pkg::SIZE_BITS-1:0]   req_size,
    input  logic [ffra_pkg::ALIGN_BITS-1:0]  align_bytes,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   free_offset,
    output logic [1:0]                       status,
    output logic [ffra_pkg::ADDR_BITS-1:0]   alloc_offset,
    output logic [ffra_pkg::SIZE_BITS-1:0]   used_bytes
);

    localparam int AW = ffra_pkg::ADDR_BITS;
    localparam int IW = ffra_pkg::IDX_BITS;
    localparam int CW = ffra_pkg::CNT_BITS;
    localparam int SW = ffra_pkg::SIZE_BITS;
    localparam int EW = AW + 2;   // room for sums past the pool end

    // Request registers.
    logic          op_reg;
    logic [SW-1:0] size_reg;
    logic [ffra_pkg::ALIGN_BITS-1:0] align_reg;
    logic [AW-1:0] off_reg;

    logic [SW-1:0] pool_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] used_reg;
    logic [CW-1:0] scan_reg;
    logic [CW-1:0] sh_reg;      // shift cursor
    logic          sh_up_reg;
    logic [CW-1:0] sh_stop_reg;
    logic [1:0]    stat_reg;
    logic [AW-1:0] aoff_reg;

    // Chosen edit, captured at the end of the walk.
    logic [CW-1:0] pos_reg;
    logic [AW-1:0] e1s_reg, e1l_reg, e2s_reg, e2l_reg;
    logic          e2_reg;
    logic          cnt_up_reg, cnt_dn_reg;
    logic          prev_valid_reg;
    logic [AW-1:0] prev_last_reg;
    logic [AW-1:0] prev_start_reg;

    // Entry 0 is reinitialized through the write port; until that write lands,
    // an override holds its value so reset needs no RAM write.
    logic init_reg;

    // RAM port.
    logic                 we;
    logic [IW-1:0]        waddr, raddr;
    logic [2*AW-1:0]      wdata, rdata;
    logic [IW-1:0]        raddr_reg;
    logic [2*AW-1:0]      rd_word;

    ffra_ram #(.WIDTH(ffra_pkg::RAM_WIDTH), .DEPTH(ffra_pkg::MAX_FREE_REGIONS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_word = (init_reg && (raddr_reg == '0)) ?
                     {AW'(0), AW'(ffra_pkg::POOL_RESET - 1'b1)} : rdata;

    logic [AW-1:0] rs, rl;
    assign rs = rd_word[2*AW-1:AW];
    assign rl = rd_word[AW-1:0];

    // Allocation fit check on the entry just read.
    logic [EW-1:0] amask, a_ext, end_ext, l_ext, s_ext;
    logic          fit, lead, trail;
    logic [EW-1:0] fend_ext;
    logic          in_range;
    assign amask    = EW'(align_reg) - EW'(1);
    assign s_ext    = EW'(rs);
    assign l_ext    = EW'(rl);
    assign a_ext    = (s_ext + amask) & ~amask;
    assign end_ext  = a_ext + EW'(size_reg) - EW'(1);
    assign fit      = in_range && (a_ext <= l_ext) && (end_ext <= l_ext);
    assign lead     = a_ext > s_ext;
    assign trail    = l_ext > end_ext;
    assign in_range = scan_reg < count_reg;
    assign fend_ext = EW'(off_reg) + EW'(size_reg) - EW'(1);

    logic full_tbl;
    assign full_tbl = count_reg >= CW'(ffra_pkg::MAX_FREE_REGIONS);

    // Free: walk stops at the first entry starting above the offset.
    logic fstop;
    assign fstop = !in_range || (rs > off_reg);
    logic jprev, jnext;
    assign jprev = prev_valid_reg && (EW'(prev_last_reg) + EW'(1) == EW'(off_reg));
    assign jnext = in_range && (EW'(rs) == fend_ext + EW'(1));

    logic bad_req;
    always_comb
    begin
        if (!op_reg)
        begin
            bad_req = (align_reg == '0) || ((align_reg & (align_reg - 1'b1)) != '0)
                      || (size_reg == '0);
        end
        else
        begin
            bad_req = (size_reg == '0) || (SW'(off_reg) >= pool_reg)
                      || (size_reg > pool_reg - SW'(off_reg));
        end
    end

    always_comb
    begin
        st           = '0;
        st.req_bad   = bad_req;
        st.is_free   = op_reg;
        st.two_edits = e2_reg;
        st.shift_end = sh_up_reg ? (sh_reg == sh_stop_reg) : (sh_reg + 1'b1 >= sh_stop_reg);
        if (!op_reg)
        begin
            st.hit      = fit;
            st.scan_end = !in_range;
            st.full     = fit && lead && trail && full_tbl;
            st.need_open  = fit && lead && trail;
            st.need_close = fit && !lead && !trail;
        end
        else
        begin
            st.hit        = fstop;
            st.scan_end   = fstop;
            st.full       = !jprev && !jnext && full_tbl;
            st.need_open  = !jprev && !jnext;
            st.need_close = jprev && jnext;
        end
    end

    logic [SW-1:0] pool_clamp;
    always_comb
    begin
        pool_clamp = cfg_we ? cfg_wdata : pool_reg;
        if (pool_clamp == '0)
        begin
            pool_clamp = SW'(1);
        end
        else if (pool_clamp > ffra_pkg::POOL_RESET)
        begin
            pool_clamp = ffra_pkg::POOL_RESET;
        end
    end

    // RAM address and write selection.
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = raddr_reg;
        if (cmd.rd_scan)
        begin
            raddr = cmd.inc_scan ? IW'(scan_reg + 1'b1) : IW'(scan_reg);
        end
        if (cmd.shift_rd)
        begin
            raddr = sh_up_reg ? IW'(sh_reg - 1'b1) : IW'(sh_reg + 1'b1);
        end
        if (cmd.shift_wr)
        begin
            we    = 1'b1;
            waddr = IW'(sh_reg);
            wdata = rd_word;
        end
        if (cmd.edit)
        begin
            we    = 1'b1;
            waddr = IW'(pos_reg);
            wdata = {e1s_reg, e1l_reg};
        end
        if (cmd.edit2)
        begin
            we    = 1'b1;
            waddr = IW'(pos_reg + 1'b1);
            wdata = {e2s_reg, e2l_reg};
        end
        if (cfg_we)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = {AW'(0), AW'(pool_clamp - 1'b1)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= op;
            size_reg  <= req_size;
            align_reg <= align_bytes;
            off_reg   <= free_offset;
        end
        raddr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg       <= ffra_pkg::POOL_RESET;
            count_reg      <= CW'(1);
            used_reg       <= '0;
            scan_reg       <= '0;
            sh_reg         <= '0;
            sh_up_reg      <= 1'b0;
            sh_stop_reg    <= '0;
            stat_reg       <= '0;
            aoff_reg       <= '0;
            pos_reg        <= '0;
            e1s_reg        <= '0;
            e1l_reg        <= '0;
            e2s_reg        <= '0;
            e2l_reg        <= '0;
            e2_reg         <= 1'b0;
            cnt_up_reg     <= 1'b0;
            cnt_dn_reg     <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_last_reg  <= '0;
            init_reg       <= 1'b1;
        end
        else if (cfg_we)
        begin
            pool_reg  <= pool_clamp;
            count_reg <= CW'(1);
            used_reg  <= '0;
            scan_reg  <= '0;
            init_reg  <= 1'b0;
        end
        else
        begin
            if (we && (waddr == '0))
            begin
                init_reg <= 1'b0;
            end
            if (cmd.clr_scan)
            begin
                scan_reg       <= '0;
                prev_valid_reg <= 1'b0;
                stat_reg       <= ffra_pkg::ST_BAD;
                aoff_reg       <= '0;
                e2_reg         <= 1'b0;
                cnt_up_reg     <= 1'b0;
                cnt_dn_reg     <= 1'b0;
            end
            if (cmd.inc_scan)
            begin
                scan_reg       <= scan_reg + 1'b1;
                prev_valid_reg <= 1'b1;
                prev_last_reg  <= rl;
            end
            if (cmd.eval && (st.hit || st.scan_end))
            begin
                if (!op_reg)
                begin
                    if (!fit)
                    begin
                        stat_reg <= ffra_pkg::ST_NOFIT;
                    end
                    else if (st.full)
                    begin
                        stat_reg <= ffra_pkg::ST_FULL;
                    end
                    else
                    begin
                        stat_reg   <= ffra_pkg::ST_OK;
                        aoff_reg   <= a_ext[AW-1:0];
                        pos_reg    <= scan_reg;
                        cnt_up_reg <= lead && trail;
                        cnt_dn_reg <= !lead && !trail;
                        e1s_reg    <= (!lead && trail) ? AW'(end_ext + EW'(1)) : rs;
                        e1l_reg    <= lead ? AW'(a_ext - EW'(1)) : rl;
                        e2_reg  <= lead && trail;
                        e2s_reg <= AW'(end_ext + EW'(1));
                        e2l_reg <= rl;
                        if (lead && trail)
                        begin
                            sh_up_reg   <= 1'b1;
                            sh_reg      <= count_reg;
                            sh_stop_reg <= scan_reg + 1'b1;
                        end
                        else
                        begin
                            sh_up_reg   <= 1'b0;
                            sh_reg      <= scan_reg;
                            sh_stop_reg <= count_reg;
                        end
                    end
                end
                else
                begin
                    if (st.full)
                    begin
                        stat_reg <= ffra_pkg::ST_FULL;
                    end
                    else
                    begin
                        stat_reg <= ffra_pkg::ST_OK;
                        if (jprev && jnext)
                        begin
                            // Previous entry absorbs both; entry k is removed.
                            pos_reg     <= scan_reg - 1'b1;
                            e1s_reg     <= prev_start_reg;
                            e1l_reg     <= rl;
                            cnt_dn_reg  <= 1'b1;
                            sh_up_reg   <= 1'b0;
                            sh_reg      <= scan_reg;
                            sh_stop_reg <= count_reg;
                        end
                        else if (jprev)
                        begin
                            pos_reg <= scan_reg - 1'b1;
                            e1s_reg <= prev_start_reg;
                            e1l_reg <= fend_ext[AW-1:0];
                        end
                        else if (jnext)
                        begin
                            pos_reg <= scan_reg;
                            e1s_reg <= off_reg;
                            e1l_reg <= rl;
                        end
                        else
                        begin
                            pos_reg     <= scan_reg;
                            e1s_reg     <= off_reg;
                            e1l_reg     <= fend_ext[AW-1:0];
                            cnt_up_reg  <= 1'b1;
                            sh_up_reg   <= 1'b1;
                            sh_reg      <= count_reg;
                            sh_stop_reg <= scan_reg;
                        end
                    end
                end
            end
            if (cmd.shift_wr)
            begin
                sh_reg <= sh_up_reg ? sh_reg - 1'b1 : sh_reg + 1'b1;
            end
            if (cmd.finish && (stat_reg == ffra_pkg::ST_OK))
            begin
                if (cnt_up_reg)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (cnt_dn_reg)
                begin
                    count_reg <= count_reg - 1'b1;
                end
                if (!op_reg)
                begin
                    used_reg <= (ffra_pkg::USED_MAX - used_reg < size_reg) ?
                                ffra_pkg::USED_MAX : used_reg + size_reg;
                end
                else
                begin
                    used_reg <= (used_reg < size_reg) ? '0 : used_reg - size_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.inc_scan)
        begin
            prev_start_reg <= rs;
        end
    end

    always_comb
    begin
        status       = stat_reg;
        alloc_offset = (stat_reg == ffra_pkg::ST_OK && !op_reg) ? aoff_reg : '0;
        used_bytes   = used_reg;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ffra_pkg::MAX_FREE_REGIONS))
        else $error("region count past table size");
    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && stat_reg == ffra_pkg::ST_FULL) |=> $stable(count_reg))
        else $error("table changed on full status");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= count_reg)
        else $error("walk index past region count");

endmodule

/* rtl/first_fit_region_allocator_unit.sv */
// ============================================================================
// first_fit_region_allocator_unit
// First-fit allocator over a byte pool with an address-ordered free table.
// ============================================================================
// Usage: one request is transferred on the in_valid/in_ready channel (op,
// req_size, align_bytes, free_offset). The block walks its free-region table
// entry by entry, held in a single registered-read RAM, then shifts
// table entries by one place when a region is split, inserted or removed,
// again entry by entry. The entries walked plus the entries shifted
// never exceed 65 for one request. Requests are handled one at a time:
// in_ready is high only while the block is idle.
// The result (status, alloc_offset, used_bytes) is held on out_valid until the
// receiver takes it; while the receiver stalls, no new request is accepted.
// Reset leaves one free region covering 2^24 bytes and no bytes in use.
// Writing pool_bytes (cfg_we, cfg_wdata) resets the table to one region
// covering the new pool and clears the byte count; the value is clamped to
// the range 1 to 2^24.
// ============================================================================
module first_fit_region_allocator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ffra_pkg::SIZE_BITS-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [ffra_pkg::SIZE_BITS-1:0]  req_size,
    input  logic [ffra_pkg::ALIGN_BITS-1:0] align_bytes,
    input  logic [ffra_pkg::ADDR_BITS-1:0]  free_offset,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [ffra_pkg::ADDR_BITS-1:0]  alloc_offset,
    output logic [ffra_pkg::SIZE_BITS-1:0]  used_bytes
);

    ffra_pkg::cmd_t  cmd;
    ffra_pkg::stat_t st;
    logic            idle;
    logic            out_valid_reg;
    logic            in_fire;
    logic            out_fire;

    assign in_ready = idle && !cfg_we;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;

    // The result register is loaded when the request completes and cleared
    // on its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_valid_set)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    ffra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .cfg_we   (cfg_we),
        .st       (st),
        .cmd      (cmd),
        .idle     (idle)
    );

    ffra_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .op           (op),
        .req_size     (req_size),
        .align_bytes  (align_bytes),
        .free_offset  (free_offset),
        .status       (status),
        .alloc_offset (alloc_offset),
        .used_bytes   (used_bytes)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("request taken while a result waits");
    a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> !out_valid_reg)
        else $error("result repeated after transfer");
    a_in_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("block idle right after taking a request");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the first-fit region allocator. Requests are driven
// over a valid/ready channel with random gaps; a scoreboard predicts status,
// offset and byte count from its own copy of the free-region table.
// ============================================================================

// The scoreboard keeps a software image of the free table and a FIFO of the
// results that the block owes.
class region_scoreboard;
    int unsigned pool;
    longint unsigned first_byte[$];
    longint unsigned last_byte[$];
    longint unsigned in_use;
    ffra_pkg::status_t exp_status[$];
    logic [23:0] exp_offset[$];
    logic [24:0] exp_used[$];
    int errors;

    function void set_pool(longint unsigned value);
        longint unsigned v;
        v = value & 64'h1ffffff;
        if (v < 1) v = 1;
        if (v > (64'd1 << 24)) v = 64'd1 << 24;
        pool = v;
        first_byte = {};
        last_byte = {};
        first_byte.insert(0, 0);
        last_byte.insert(0, v - 1);
        in_use = 0;
    endfunction

    function void run_alloc(longint unsigned size, longint unsigned align,
                            output ffra_pkg::status_t st, output logic [23:0] offs);
        longint unsigned s, l, a, e;
        bit lead, trail;
        st = ffra_pkg::ST_NOFIT;
        offs = 0;
        if (align == 0 || (align & (align - 1)) != 0 || size == 0)
        begin
            st = ffra_pkg::ST_BAD;
            return;
        end
        for (int i = 0; i < first_byte.size(); i++)
        begin
            s = first_byte[i];
            l = last_byte[i];
            a = (s + align - 1) & ~(align - 1);
            if (a > l || l - a + 1 < size) continue;
            e = a + size - 1;
            lead = a > s;
            trail = l > e;
            if (lead && trail)
            begin
                if (first_byte.size() >= ffra_pkg::MAX_FREE_REGIONS)
                begin
                    st = ffra_pkg::ST_FULL;
                    return;
                end
                last_byte[i] = a - 1;
                first_byte.insert(i + 1, e + 1);
                last_byte.insert(i + 1, l);
            end
            else if (lead) last_byte[i] = a - 1;
            else if (trail) first_byte[i] = e + 1;
            else
            begin
                first_byte.delete(i);
                last_byte.delete(i);
            end
            in_use = (33554431 - in_use < size) ? 33554431 : in_use + size;
            offs = a[23:0];
            st = ffra_pkg::ST_OK;
            return;
        end
    endfunction

    function ffra_pkg::status_t run_free(longint unsigned off, longint unsigned size);
        longint unsigned e;
        int k;
        bit jp, jn;
        if (size == 0 || off >= pool || size > pool - off) return ffra_pkg::ST_BAD;
        e = off + size - 1;
        k = 0;
        while (k < first_byte.size() && first_byte[k] <= off) k++;
        jp = k > 0 && last_byte[k - 1] + 1 == off;
        jn = k < first_byte.size() && first_byte[k] == e + 1;
        if (jp && jn)
        begin
            last_byte[k - 1] = last_byte[k];
            first_byte.delete(k);
            last_byte.delete(k);
        end
        else if (jp) last_byte[k - 1] = e;
        else if (jn) first_byte[k] = off;
        else
        begin
            if (first_byte.size() >= ffra_pkg::MAX_FREE_REGIONS) return ffra_pkg::ST_FULL;
            first_byte.insert(k, off);
            last_byte.insert(k, e);
        end
        in_use = (in_use < size) ? 0 : in_use - size;
        return ffra_pkg::ST_OK;
    endfunction

    // Note an accepted request and queue the result it must produce.
    function void note_request(bit is_free, longint unsigned size, longint unsigned align,
                               longint unsigned off);
        ffra_pkg::status_t st;
        logic [23:0] offs;
        offs = 0;
        size = size & 64'h1ffffff;
        align = align & 64'h1ffff;
        off = off & 64'hffffff;
        if (is_free) st = run_free(off, size);
        else run_alloc(size, align, st, offs);
        exp_status.insert(exp_status.size(), st);
        exp_offset.insert(exp_offset.size(), offs);
        exp_used.insert(exp_used.size(), in_use[24:0]);
    endfunction

    task report(string what);
        $display("MISMATCH %s at %0t", what, $time);
        errors++;
    endtask

    task check_result(logic [1:0] st, logic [23:0] offs, logic [24:0] used);
        if (exp_status.size() == 0)
        begin
            report("unexpected result");
            return;
        end
        if (st !== exp_status[0])
            report($sformatf("status got %0d exp %0d", st, exp_status[0]));
        if (offs !== exp_offset[0])
            report($sformatf("offset got %0h exp %0h", offs, exp_offset[0]));
        if (used !== exp_used[0])
            report($sformatf("used got %0d exp %0d", used, exp_used[0]));
        void'(exp_status.pop_front());
        void'(exp_offset.pop_front());
        void'(exp_used.pop_front());
    endtask

    function int pending();
        return exp_status.size();
    endfunction
endclass

module tb_top;

    logic                            clk = 0;
    logic                            rst_n = 0;
    logic                            cfg_we = 0;
    logic [ffra_pkg::SIZE_BITS-1:0]  cfg_wdata = 0;
    logic                            in_valid = 0;
    logic                            in_ready;
    logic                            op = 0;
    logic [ffra_pkg::SIZE_BITS-1:0]  req_size = 0;
    logic [ffra_pkg::ALIGN_BITS-1:0] align_bytes = 0;
    logic [ffra_pkg::ADDR_BITS-1:0]  free_offset = 0;
    logic                            out_valid;
    logic                            out_ready = 0;
    logic [1:0]                      status;
    logic [ffra_pkg::ADDR_BITS-1:0]  alloc_offset;
    logic [ffra_pkg::SIZE_BITS-1:0]  used_bytes;

    region_scoreboard board = new();
    longint unsigned cycles = 0;
    // While set, the receiver refuses every result so the block backs up.
    bit hold_results = 0;
    // Offsets and sizes of live allocations, used to build sensible frees.
    longint unsigned live_off[$];
    longint unsigned live_len[$];

    always #2 clk = ~clk;

    first_fit_region_allocator_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .req_size(req_size),
        .align_bytes(align_bytes), .free_offset(free_offset), .out_valid(out_valid),
        .out_ready(out_ready), .status(status), .alloc_offset(alloc_offset),
        .used_bytes(used_bytes)
    );

    // Cycle watchdog. It ends the run and reports errors if the bench hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd2000000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Short gaps most of the time, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    // Results are checked at the edge where the transfer completes.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(status, alloc_offset, used_bytes);
    end

    initial
    begin
        int g;
        @(posedge clk);
        forever
        begin
            if (hold_results)
                out_ready <= 0;
            else
            begin
                g = gap_length();
                out_ready <= (g == 0) || ($urandom_range(0, 3) == 0);
            end
            @(posedge clk);
        end
    end

    // One request transfer; the predictor sees it at the accepting edge.
    // Valid stays high across back-to-back requests and drops only in a gap.
    task automatic send_request(bit is_free, longint unsigned size, longint unsigned align,
                                longint unsigned off);
        int g;
        g = gap_length();
        if (g != 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        op <= is_free;
        req_size <= size[24:0];
        align_bytes <= align[16:0];
        free_offset <= off[23:0];
        do @(posedge clk); while (!in_ready);
        board.note_request(is_free, size, align, off);
        if (!is_free && board.exp_status[board.exp_status.size() - 1] == ffra_pkg::ST_OK)
        begin
            live_off.insert(live_off.size(), board.exp_offset[board.exp_offset.size() - 1]);
            live_len.insert(live_len.size(), size);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_pool(longint unsigned value);
        drain();
        cfg_we <= 1;
        cfg_wdata <= value[24:0];
        @(posedge clk);
        cfg_we <= 0;
        board.set_pool(value);
        live_off = {};
        live_len = {};
    endtask

    function automatic longint unsigned random_align();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(0, 131071);
        if (r == 2) return 65536;
        return 64'd1 << $urandom_range(0, 8);
    endfunction

    // Mostly allocate and free real blocks, with some random noise.
    task automatic random_phase(int count, longint unsigned pool);
        int r, k;
        longint unsigned size, off;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, pool)
                       : $urandom_range(1, (pool > 64) ? pool / 16 : pool);
                send_request(0, size, random_align(), 0);
            end
            else if (r < 88 && live_off.size() > 0)
            begin
                k = $urandom_range(0, live_off.size() - 1);
                off = live_off[k];
                size = live_len[k];
                // Sometimes free only the tail part to create fragments.
                if (size > 1 && $urandom_range(0, 3) == 0)
                begin
                    off = off + size / 2;
                    size = size - size / 2;
                end
                live_off.delete(k);
                live_len.delete(k);
                send_request(1, size, $urandom_range(0, 131071), off);
            end
            else
                send_request($urandom_range(0, 1), {$urandom_range(0, 1), $urandom()} & 25'h1ffffff,
                             $urandom_range(0, 131071), $urandom() & 24'hffffff);
        end
    endtask

    initial
    begin
        longint unsigned full_pool;
        full_pool = 64'd1 << 24;
        board.set_pool(full_pool);
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes and the bad, no-fit and ok status cases on the reset pool.
        send_request(0, 0, 1, 0);
        send_request(0, 16, 0, 0);
        send_request(0, 16, 3, 0);
        send_request(0, 25'h1ffffff, 1, 0);
        send_request(0, 100, 65536, 0);
        send_request(0, 10, 131071, 0);
        send_request(0, 7, 1, 0);
        send_request(0, 8, 65536, 0);
        send_request(1, 0, 1, 5);
        send_request(1, 2, 0, 24'hffffff);
        send_request(1, 7, 0, 0);
        send_request(1, 8, 1, 65536);
        send_request(1, 5, 0, 24'hfffff0);
        send_request(0, full_pool, 1, 0);
        send_request(1, full_pool, 1, 0);
        send_request(1, 3, 1, 100);

        // Long receiver hold-off while requests keep coming.
        fork
            begin
                hold_results = 1;
                repeat (400) @(posedge clk);
                hold_results = 0;
            end
            random_phase(6, full_pool);
        join

        // Tiny pool: splits the free table into many one-byte fragments.
        write_pool(200);
        for (int i = 0; i < 100; i++) send_request(0, 1, 1, 0);
        for (int i = 0; i < 100; i += 2) send_request(1, 1, 1, i);
        send_request(0, 1, 2, 0);
        random_phase(150, 200);

        write_pool(1);
        send_request(0, 1, 1, 0);
        send_request(0, 1, 1, 0);
        send_request(1, 1, 1, 0);
        random_phase(20, 1);

        write_pool(0);
        random_phase(20, 1);

        write_pool(25'h1ffffff);
        random_phase(400, full_pool);

        write_pool(4096);
        random_phase(500, 4096);

        write_pool(full_pool);
        random_phase(300, full_pool);

        drain();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* filelist.f */
rtl/ffra_pkg.sv
rtl/ffra_ram.sv
rtl/ffra_ctrl.sv
rtl/ffra_dp.sv
rtl/first_fit_region_allocator_unit.sv
test/tb_top.sv
